// ----- design/lpcp_pkg.sv -----
// shared types, widths and helpers for the line/polygon crossing parity block
`timescale 1ns / 1ps

package lpcp_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = ADDR_W + 1;

    localparam int FIELD_W    = 20;
    localparam int COORD_BITS = 20;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int MUL_W      = DIFF_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CROSS_W    = 2 * COORD_BITS + 1;
    localparam int LO_W       = COORD_BITS;
    localparam int HI_W       = CROSS_W - LO_W;
    localparam int DEN_W      = 2 * DIFF_W + 2;
    localparam int ACC_W      = DIFF_W + CROSS_W + 2;
    localparam int POINT_W    = 2 * COORD_BITS;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_LINE   = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_C,
        DST_CP,
        DST_DEN,
        DST_NUMX,
        DST_NUMY
    } dest_t;

    typedef struct packed {
        logic  valid;
        logic  first;
        logic  last;
        logic  shift;
        logic  sub;
        dest_t dest;
    } mac_op_t;

    typedef struct packed {
        logic  valid;
        dest_t dest;
    } mac_res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LINE,
        ST_LINE_WT,
        ST_V0_RD,
        ST_V0_WT,
        ST_NXT_RD,
        ST_NXT_WT,
        ST_EDGE,
        ST_EDGE_WT,
        ST_DX_GO,
        ST_DX_WT,
        ST_DY_GO,
        ST_DY_WT,
        ST_CHECK,
        ST_EDGE_NXT,
        ST_Q_RUN,
        ST_Q_DONE
    } state_t;

    // coordinate from the low COORD_BITS of a field
    function automatic logic signed [COORD_BITS-1:0] sext(input logic [FIELD_W-1:0] v);
        sext = $signed(v[COORD_BITS-1:0]);
    endfunction

endpackage

// ----- design/line_polygon_crossing_parity.sv -----
// top level: polygon store, line/edge intersection sequencer and point query
// a query walks every stored crossing, and goes straight to its result if there are none
// set-line walks every polygon edge: one shared multiplier runs twelve
// products per edge, one radix-2 divider runs two 64-bit divisions per non-parallel edge
// the block takes one transaction at a time; the result register frees the input side
// reset (aresetn low, synchronous) clears both counts and the control state;
// the vertex and crossing memories are not cleared and need no sweep
`timescale 1ns / 1ps

module line_polygon_crossing_parity (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // px[19:0], py[39:20], qx[59:40], qy[79:60]
    input  logic [1:0]  s_tuser,  // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // parity[0], zero fill
);

    localparam int CB = lpcp_pkg::COORD_BITS;
    localparam int AW = lpcp_pkg::ADDR_W;
    localparam int NW = lpcp_pkg::CNT_W;
    localparam int MW = lpcp_pkg::MUL_W;
    localparam int XW = lpcp_pkg::ACC_W;
    localparam int PW = lpcp_pkg::POINT_W;
    localparam int LW = lpcp_pkg::LO_W;

    lpcp_pkg::state_t state_reg, state_next;

    logic [NW-1:0] vcount_reg, ccount_reg, edge_reg, qk_reg;
    logic [3:0]    step_reg;
    logic signed [CB-1:0] lx1_reg, ly1_reg, lx2_reg, ly2_reg;
    logic signed [CB-1:0] ex_reg, ey_reg, fx_reg, fy_reg, v0x_reg, v0y_reg;
    logic signed [CB-1:0] qpx_reg, qpy_reg;
    logic signed [lpcp_pkg::DIFF_W-1:0]  a_reg, b_reg, ap, bp;
    logic signed [lpcp_pkg::CROSS_W-1:0] c_reg, cp_reg;
    logic signed [lpcp_pkg::DEN_W-1:0]   den_reg;
    logic signed [XW-1:0] numx_reg, numy_reg, ix_reg, iy_reg;
    logic rv_reg, par_reg, m_valid_reg, m_par_reg;

    logic s_fire;
    logic [1:0] opcode;
    logic signed [CB-1:0] in_px, in_py, in_qx, in_qy;
    logic [NW-1:0] edge_inc;
    logic last_edge;

    // memory and unit controls
    logic          v_we;
    logic [AW-1:0] v_raddr;
    logic [PW-1:0] v_rdata;
    logic          c_we;
    logic [AW-1:0] c_raddr;
    logic [PW-1:0] c_rdata;
    logic          in_box;
    lpcp_pkg::mac_op_t  mop;
    lpcp_pkg::mac_res_t mres;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [XW-1:0] mac_value;
    logic          div_start, div_flip, div_done;
    logic signed [XW-1:0] div_num, div_q;
    logic signed [CB-1:0] rd_cx, rd_cy;

    function automatic logic signed [lpcp_pkg::DIFF_W-1:0] DIFF_EXT(
        input logic signed [CB-1:0] v);
        DIFF_EXT = lpcp_pkg::DIFF_W'(v);
    endfunction

    function automatic logic signed [MW-1:0] hi_part(
        input logic signed [lpcp_pkg::CROSS_W-1:0] v);
        hi_part = MW'($signed(v[lpcp_pkg::CROSS_W-1:LW]));
    endfunction

    function automatic logic signed [MW-1:0] lo_part(
        input logic signed [lpcp_pkg::CROSS_W-1:0] v);
        lo_part = $signed({{(MW - LW){1'b0}}, v[LW-1:0]});
    endfunction

    assign opcode   = s_tuser;
    assign in_px    = lpcp_pkg::sext(s_tdata[19:0]);
    assign in_py    = lpcp_pkg::sext(s_tdata[39:20]);
    assign in_qx    = lpcp_pkg::sext(s_tdata[59:40]);
    assign in_qy    = lpcp_pkg::sext(s_tdata[79:60]);
    assign s_tready = (state_reg == lpcp_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign edge_inc = NW'(edge_reg + 1'b1);
    assign last_edge = (edge_inc == vcount_reg);
    assign ap = DIFF_EXT(fy_reg) - DIFF_EXT(ey_reg);
    assign bp = DIFF_EXT(ex_reg) - DIFF_EXT(fx_reg);
    assign rd_cx = $signed(c_rdata[CB-1:0]);
    assign rd_cy = $signed(c_rdata[PW-1:CB]);

    lpcp_ram #(.DATA_W(PW), .DEPTH(lpcp_pkg::MAX_VERTICES)) u_vram (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (vcount_reg[AW-1:0]),
        .wdata ({in_py, in_px}),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    lpcp_ram #(.DATA_W(PW), .DEPTH(lpcp_pkg::MAX_VERTICES)) u_cram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (ccount_reg[AW-1:0]),
        .wdata ({iy_reg[CB-1:0], ix_reg[CB-1:0]}),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    lpcp_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (mop),
        .op_a      (mul_a),
        .op_b      (mul_b),
        .res       (mres),
        .res_value (mac_value)
    );

    lpcp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den_reg),
        .flip    (div_flip),
        .done    (div_done),
        .quot    (div_q)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lpcp_pkg::ST_IDLE: begin
                if (s_fire && opcode == lpcp_pkg::OP_LINE) begin
                    state_next = lpcp_pkg::ST_LINE;
                end else if (s_fire && opcode == lpcp_pkg::OP_QUERY) begin
                    state_next = (ccount_reg == '0) ? lpcp_pkg::ST_Q_DONE
                                                    : lpcp_pkg::ST_Q_RUN;
                end
            end
            lpcp_pkg::ST_LINE:
                if (step_reg == 4'd1) state_next = lpcp_pkg::ST_LINE_WT;
            lpcp_pkg::ST_LINE_WT:
                if (mres.valid && mres.dest == lpcp_pkg::DST_C) begin
                    state_next = (vcount_reg == '0) ? lpcp_pkg::ST_IDLE
                                                    : lpcp_pkg::ST_V0_RD;
                end
            lpcp_pkg::ST_V0_RD:  state_next = lpcp_pkg::ST_V0_WT;
            lpcp_pkg::ST_V0_WT:  state_next = lpcp_pkg::ST_NXT_RD;
            lpcp_pkg::ST_NXT_RD:
                state_next = last_edge ? lpcp_pkg::ST_EDGE : lpcp_pkg::ST_NXT_WT;
            lpcp_pkg::ST_NXT_WT: state_next = lpcp_pkg::ST_EDGE;
            lpcp_pkg::ST_EDGE:
                if (step_reg == 4'd13) state_next = lpcp_pkg::ST_EDGE_WT;
            lpcp_pkg::ST_EDGE_WT:
                if (mres.valid && mres.dest == lpcp_pkg::DST_NUMY) begin
                    // parallel edge: nothing to divide
                    state_next = (den_reg == '0) ? lpcp_pkg::ST_EDGE_NXT
                                                 : lpcp_pkg::ST_DX_GO;
                end
            lpcp_pkg::ST_DX_GO:  state_next = lpcp_pkg::ST_DX_WT;
            lpcp_pkg::ST_DX_WT:  if (div_done) state_next = lpcp_pkg::ST_DY_GO;
            lpcp_pkg::ST_DY_GO:  state_next = lpcp_pkg::ST_DY_WT;
            lpcp_pkg::ST_DY_WT:  if (div_done) state_next = lpcp_pkg::ST_CHECK;
            lpcp_pkg::ST_CHECK:  state_next = lpcp_pkg::ST_EDGE_NXT;
            lpcp_pkg::ST_EDGE_NXT:
                state_next = last_edge ? lpcp_pkg::ST_IDLE : lpcp_pkg::ST_NXT_RD;
            lpcp_pkg::ST_Q_RUN:
                if (qk_reg == ccount_reg && !rv_reg) state_next = lpcp_pkg::ST_Q_DONE;
            lpcp_pkg::ST_Q_DONE:
                if (!m_valid_reg || m_tready) state_next = lpcp_pkg::ST_IDLE;
            default: state_next = lpcp_pkg::ST_IDLE;
        endcase
    end

    // outputs to memories and units
    always_comb begin
        v_we      = s_fire && opcode == lpcp_pkg::OP_APPEND &&
                    vcount_reg < NW'(lpcp_pkg::MAX_VERTICES);
        v_raddr   = (state_reg == lpcp_pkg::ST_NXT_RD) ? edge_inc[AW-1:0] : '0;
        c_raddr   = qk_reg[AW-1:0];
        in_box    = !(ix_reg < XW'(ex_reg) && ix_reg < XW'(fx_reg)) &&
                    !(ix_reg > XW'(ex_reg) && ix_reg > XW'(fx_reg)) &&
                    !(iy_reg < XW'(ey_reg) && iy_reg < XW'(fy_reg)) &&
                    !(iy_reg > XW'(ey_reg) && iy_reg > XW'(fy_reg));
        c_we      = (state_reg == lpcp_pkg::ST_CHECK) && in_box &&
                    ccount_reg < NW'(lpcp_pkg::MAX_VERTICES);
        div_start = (state_reg == lpcp_pkg::ST_DX_GO) || (state_reg == lpcp_pkg::ST_DY_GO);
        div_flip  = (state_reg == lpcp_pkg::ST_DY_GO);
        div_num   = div_flip ? numy_reg : numx_reg;

        mop   = '0;
        mul_a = '0;
        mul_b = '0;
        if (state_reg == lpcp_pkg::ST_LINE || state_reg == lpcp_pkg::ST_EDGE) begin
            mop.valid = 1'b1;
            unique case (step_reg)
                4'd0: begin mul_a = MW'(ly1_reg); mul_b = MW'(lx2_reg); mop.first = 1'b1; end
                4'd1: begin
                    mul_a = MW'(lx1_reg); mul_b = MW'(ly2_reg);
                    mop.sub = 1'b1; mop.last = 1'b1; mop.dest = lpcp_pkg::DST_C;
                end
                4'd2: begin mul_a = MW'(ey_reg); mul_b = MW'(fx_reg); mop.first = 1'b1; end
                4'd3: begin
                    mul_a = MW'(ex_reg); mul_b = MW'(fy_reg);
                    mop.sub = 1'b1; mop.last = 1'b1; mop.dest = lpcp_pkg::DST_CP;
                end
                4'd4: begin mul_a = MW'(a_reg); mul_b = MW'(bp); mop.first = 1'b1; end
                4'd5: begin
                    mul_a = MW'(ap); mul_b = MW'(b_reg);
                    mop.sub = 1'b1; mop.last = 1'b1; mop.dest = lpcp_pkg::DST_DEN;
                end
                4'd6: begin
                    mul_a = MW'(b_reg); mul_b = hi_part(cp_reg);
                    mop.first = 1'b1; mop.shift = 1'b1;
                end
                4'd7: begin mul_a = MW'(b_reg); mul_b = lo_part(cp_reg); end
                4'd8: begin
                    mul_a = MW'(bp); mul_b = hi_part(c_reg);
                    mop.sub = 1'b1; mop.shift = 1'b1;
                end
                4'd9: begin
                    mul_a = MW'(bp); mul_b = lo_part(c_reg);
                    mop.sub = 1'b1; mop.last = 1'b1; mop.dest = lpcp_pkg::DST_NUMX;
                end
                4'd10: begin
                    mul_a = MW'(a_reg); mul_b = hi_part(cp_reg);
                    mop.first = 1'b1; mop.shift = 1'b1;
                end
                4'd11: begin mul_a = MW'(a_reg); mul_b = lo_part(cp_reg); end
                4'd12: begin
                    mul_a = MW'(ap); mul_b = hi_part(c_reg);
                    mop.sub = 1'b1; mop.shift = 1'b1;
                end
                4'd13: begin
                    mul_a = MW'(ap); mul_b = lo_part(c_reg);
                    mop.sub = 1'b1; mop.last = 1'b1; mop.dest = lpcp_pkg::DST_NUMY;
                end
                default: mop.valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lpcp_pkg::ST_IDLE;
            vcount_reg  <= '0;
            ccount_reg  <= '0;
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == lpcp_pkg::ST_Q_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_fire && opcode == lpcp_pkg::OP_CLEAR) begin
                vcount_reg <= '0;
            end
            if (v_we) begin
                vcount_reg <= NW'(vcount_reg + 1'b1);
            end
            if (s_fire && opcode == lpcp_pkg::OP_LINE) begin
                ccount_reg <= '0;
            end
            if (c_we) begin
                ccount_reg <= NW'(ccount_reg + 1'b1);
            end
            rv_reg <= (state_reg == lpcp_pkg::ST_Q_RUN) && (qk_reg < ccount_reg);
        end

        // datapath registers
        if (s_fire) begin
            lx1_reg  <= in_px;
            ly1_reg  <= in_py;
            lx2_reg  <= in_qx;
            ly2_reg  <= in_qy;
            qpx_reg  <= in_px;
            qpy_reg  <= in_py;
            a_reg    <= DIFF_EXT(in_qy) - DIFF_EXT(in_py);
            b_reg    <= DIFF_EXT(in_px) - DIFF_EXT(in_qx);
            step_reg <= '0;
            qk_reg   <= '0;
            par_reg  <= 1'b0;
            edge_reg <= '0;
        end
        if (state_reg == lpcp_pkg::ST_LINE || state_reg == lpcp_pkg::ST_EDGE) begin
            step_reg <= step_reg + 4'd1;
        end
        if (mres.valid) begin
            unique case (mres.dest)
                lpcp_pkg::DST_C:    c_reg    <= mac_value[lpcp_pkg::CROSS_W-1:0];
                lpcp_pkg::DST_CP:   cp_reg   <= mac_value[lpcp_pkg::CROSS_W-1:0];
                lpcp_pkg::DST_DEN:  den_reg  <= mac_value[lpcp_pkg::DEN_W-1:0];
                lpcp_pkg::DST_NUMX: numx_reg <= mac_value;
                lpcp_pkg::DST_NUMY: numy_reg <= mac_value;
                default: ;
            endcase
        end
        if (state_reg == lpcp_pkg::ST_V0_WT) begin
            v0x_reg <= $signed(v_rdata[CB-1:0]);
            v0y_reg <= $signed(v_rdata[PW-1:CB]);
            ex_reg  <= $signed(v_rdata[CB-1:0]);
            ey_reg  <= $signed(v_rdata[PW-1:CB]);
        end
        // closing edge wraps to the first vertex
        if (state_reg == lpcp_pkg::ST_NXT_RD && last_edge) begin
            fx_reg <= v0x_reg;
            fy_reg <= v0y_reg;
        end
        if (state_reg == lpcp_pkg::ST_NXT_WT) begin
            fx_reg <= $signed(v_rdata[CB-1:0]);
            fy_reg <= $signed(v_rdata[PW-1:CB]);
        end
        if (state_reg == lpcp_pkg::ST_NXT_RD || state_reg == lpcp_pkg::ST_NXT_WT) begin
            step_reg <= 4'd2;
        end
        if (state_reg == lpcp_pkg::ST_DX_WT && div_done) ix_reg <= div_q;
        if (state_reg == lpcp_pkg::ST_DY_WT && div_done) iy_reg <= div_q;
        if (state_reg == lpcp_pkg::ST_EDGE_NXT) begin
            edge_reg <= edge_inc;
            ex_reg   <= fx_reg;
            ey_reg   <= fy_reg;
        end
        if (state_reg == lpcp_pkg::ST_Q_RUN && qk_reg < ccount_reg) begin
            qk_reg <= NW'(qk_reg + 1'b1);
        end
        if (rv_reg && (rd_cx < qpx_reg || (rd_cx == qpx_reg && rd_cy < qpy_reg))) begin
            par_reg <= ~par_reg;
        end
        if (state_reg == lpcp_pkg::ST_Q_DONE && (!m_valid_reg || m_tready)) begin
            m_par_reg <= par_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_par_reg};

    a_ccount_max: assert property (@(posedge aclk) disable iff (!aresetn)
        ccount_reg <= NW'(lpcp_pkg::MAX_VERTICES))
        else $error("crossing count above capacity");

    a_vcount_max: assert property (@(posedge aclk) disable iff (!aresetn)
        vcount_reg <= NW'(lpcp_pkg::MAX_VERTICES))
        else $error("vertex count above capacity");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == lpcp_pkg::ST_DX_WT || state_reg == lpcp_pkg::ST_DY_WT))
        else $error("divider finished outside a wait state");

    a_numy_edge_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (mres.valid && mres.dest == lpcp_pkg::DST_NUMY) |-> state_reg == lpcp_pkg::ST_EDGE_WT)
        else $error("edge product sequence out of step");

    a_cwrite_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        c_we |-> edge_reg < vcount_reg)
        else $error("crossing written outside the edge walk");

endmodule

// ----- design/lpcp_ram.sv -----
// simple dual port ram, one write port and one registered read port
`timescale 1ns / 1ps

module lpcp_ram #(
    parameter int DATA_W = 40,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/lpcp_mac.sv -----
// registered multiplier with a shift/add/subtract accumulator
`timescale 1ns / 1ps

module lpcp_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lpcp_pkg::mac_op_t                    op,
    input  logic signed [lpcp_pkg::MUL_W-1:0]    op_a,
    input  logic signed [lpcp_pkg::MUL_W-1:0]    op_b,
    output lpcp_pkg::mac_res_t                   res,
    output logic signed [lpcp_pkg::ACC_W-1:0]    res_value
);

    logic signed [lpcp_pkg::PROD_W-1:0] prod_reg;
    lpcp_pkg::mac_op_t                  ctl_reg;
    logic signed [lpcp_pkg::ACC_W-1:0]  acc_reg;
    logic signed [lpcp_pkg::ACC_W-1:0]  term;
    logic signed [lpcp_pkg::ACC_W-1:0]  base;
    logic signed [lpcp_pkg::ACC_W-1:0]  acc_next;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= op;
        end
        if (ctl_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        term = lpcp_pkg::ACC_W'(prod_reg);
        if (ctl_reg.shift) begin
            term = term <<< lpcp_pkg::LO_W;
        end
        base     = ctl_reg.first ? '0 : acc_reg;
        acc_next = ctl_reg.sub ? base - term : base + term;
    end

    assign res.valid = ctl_reg.valid && ctl_reg.last;
    assign res.dest  = ctl_reg.dest;
    assign res_value = acc_next;

endmodule

// ----- design/lpcp_div.sv -----
// radix-2 restoring divider, signed, truncating toward zero
`timescale 1ns / 1ps

module lpcp_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [lpcp_pkg::ACC_W-1:0]    num,
    input  logic signed [lpcp_pkg::DEN_W-1:0]    den,
    input  logic                                 flip,
    output logic                                 done,
    output logic signed [lpcp_pkg::ACC_W-1:0]    quot
);

    localparam int NW  = lpcp_pkg::ACC_W;
    localparam int DW  = lpcp_pkg::DEN_W;
    localparam int CTW = $clog2(NW + 1);

    logic [NW-1:0]  n_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  d_reg;
    logic           neg_reg;
    logic [CTW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [DW:0]    rem_sh;
    logic           ge;
    logic [DW:0]    rem_sub;

    always_comb begin
        rem_sh  = {rem_reg, n_reg[NW-1]};
        rem_sub = rem_sh - {1'b0, d_reg};
        ge      = rem_sh >= {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CTW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            n_reg   <= num[NW-1] ? NW'(-num) : NW'(num);
            d_reg   <= den[DW-1] ? DW'(-den) : DW'(den);
            rem_reg <= '0;
            neg_reg <= num[NW-1] ^ den[DW-1] ^ flip;
        end else if (busy_reg) begin
            n_reg   <= {n_reg[NW-2:0], ge};
            rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(n_reg) : $signed(n_reg);

endmodule

// ----- bench/line_polygon_crossing_parity_test.sv -----
// testbench for the line/polygon crossing parity block: directed table, random polygons, scoreboard
`timescale 1ns / 1ps

module line_polygon_crossing_parity_test;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int ITEM_GOAL    = 580;
    localparam int DRAIN_CYCLES = lpcp_pkg::MAX_VERTICES + 100;

    typedef logic signed [lpcp_pkg::COORD_BITS-1:0] coord_t;

    typedef struct {
        logic [1:0] op;
        coord_t     px;
        coord_t     py;
        coord_t     qx;
        coord_t     qy;
        int         typed;  // -1: take the parity from the predictor
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // px[19:0], py[39:20], qx[59:40], qy[79:60]
    logic [1:0]  s_tuser;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // parity[0], zero fill

    // polygon and crossing state of the predictor
    int     poly_x[lpcp_pkg::MAX_VERTICES];
    int     poly_y[lpcp_pkg::MAX_VERTICES];
    int     poly_n;
    int     hit_x[lpcp_pkg::MAX_VERTICES];
    int     hit_y[lpcp_pkg::MAX_VERTICES];
    int     hit_n;

    bit     parity_due[$];
    int     typed_parity[$];
    int     errors;
    int     sent;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_off_req;
    longint cycles;

    line_polygon_crossing_parity i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return (a < b) ? b : a;
    endfunction

    // intersect the line with every closed edge, keep hits inside the edge box
    function automatic void find_crossings(longint x1, longint y1, longint x2, longint y2);
        longint a, b, c, ex, ey, fx, fy, ap, bp, cp, den, ix, iy;
        int j;
        a = y2 - y1;
        b = x1 - x2;
        c = y1 * x2 - x1 * y2;
        hit_n = 0;
        for (int i = 0; i < poly_n; i++) begin
            j = (i + 1 == poly_n) ? 0 : i + 1;
            ex = poly_x[i];
            ey = poly_y[i];
            fx = poly_x[j];
            fy = poly_y[j];
            ap = fy - ey;
            bp = ex - fx;
            cp = ey * fx - ex * fy;
            den = a * bp - ap * b;
            if (den == 0) continue;
            ix = (b * cp - bp * c) / den;
            iy = (a * cp - ap * c) / (-den);
            if (ix < lmin(ex, fx) || ix > lmax(ex, fx) ||
                iy < lmin(ey, fy) || iy > lmax(ey, fy)) continue;
            if (hit_n < lpcp_pkg::MAX_VERTICES) begin
                hit_x[hit_n] = int'(ix);
                hit_y[hit_n] = int'(iy);
                hit_n++;
            end
        end
    endfunction

    function automatic bit parity_below(int px, int py);
        bit p;
        p = 1'b0;
        for (int k = 0; k < hit_n; k++)
            if (hit_x[k] < px || (hit_x[k] == px && hit_y[k] < py)) p = ~p;
        return p;
    endfunction

    // predictor and scoreboard, sampled at the rising edge
    always @(posedge aclk) begin
        int  typed;
        bit  want;
        coord_t px, py, qx, qy;
        if (aresetn && s_tvalid && s_tready) begin
            typed = typed_parity.pop_front();
            px = s_tdata[19:0];
            py = s_tdata[39:20];
            qx = s_tdata[59:40];
            qy = s_tdata[79:60];
            case (s_tuser)
                lpcp_pkg::OP_CLEAR: poly_n = 0;
                lpcp_pkg::OP_APPEND: begin
                    if (poly_n < lpcp_pkg::MAX_VERTICES) begin
                        poly_x[poly_n] = px;
                        poly_y[poly_n] = py;
                        poly_n++;
                    end
                end
                lpcp_pkg::OP_LINE: find_crossings(px, py, qx, qy);
                default: begin
                    want = parity_below(px, py);
                    if (typed >= 0) want = typed[0];
                    parity_due.push_back(want);
                end
            endcase
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (parity_due.size() == 0) begin
                $error("parity: result transaction with nothing expected, actual %0d",
                       m_tdata[0]);
                errors++;
            end else begin
                want = parity_due.pop_front();
                if (m_tdata[0] !== want) begin
                    $error("parity: expected %0d, actual %0d", want, m_tdata[0]);
                    errors++;
                end
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (4000) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
                @(posedge aclk);
            end
        end
    end

    task automatic offer(input logic [1:0] op, input coord_t px, input coord_t py,
                         input coord_t qx, input coord_t qy, input int typed);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        typed_parity.push_back(typed);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {qy, qx, py, px};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (parity_due.size() != 0) @(posedge aclk);
    endtask

    function automatic coord_t any_coord(int spread);
        case (spread)
            0:       return coord_t'($urandom_range(0, 40)) - 20;
            1:       return coord_t'($urandom_range(0, 4000)) - 2000;
            default: return coord_t'($urandom);
        endcase
    endfunction

    // one polygon with a random line and queries, mostly around the crossings
    task automatic polygon_round();
        int nv, spread, nq, k;
        coord_t x, y;
        spread = $urandom_range(0, 2);
        nv = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
        offer(lpcp_pkg::OP_CLEAR, any_coord(2), any_coord(2), any_coord(2), any_coord(2), -1);
        for (int i = 0; i < nv; i++)
            offer(lpcp_pkg::OP_APPEND, any_coord(spread), any_coord(spread), any_coord(2),
                  any_coord(2), -1);
        if ($urandom_range(0, 15) == 0) begin
            x = any_coord(spread);
            y = any_coord(spread);
            offer(lpcp_pkg::OP_LINE, x, y, x, y, -1);
        end else begin
            offer(lpcp_pkg::OP_LINE, any_coord(spread), any_coord(spread), any_coord(spread),
                  any_coord(spread), -1);
        end
        wait_drained();
        nq = $urandom_range(3, 8);
        for (int i = 0; i < nq; i++) begin
            if (hit_n > 0 && $urandom_range(0, 3) != 0) begin
                k = $urandom_range(0, hit_n - 1);
                x = coord_t'(hit_x[k] + $urandom_range(0, 2) - 1);
                y = coord_t'(hit_y[k] + $urandom_range(0, 2) - 1);
            end else begin
                x = any_coord(spread);
                y = any_coord(spread);
            end
            offer(lpcp_pkg::OP_QUERY, x, y, any_coord(2), any_coord(2), -1);
        end
        // stray transactions now and then
        if ($urandom_range(0, 4) == 0)
            offer(logic'($urandom_range(0, 1)) ? lpcp_pkg::OP_APPEND : lpcp_pkg::OP_QUERY,
                  any_coord(2), any_coord(2), any_coord(2), any_coord(2), -1);
        if ($urandom_range(0, 4) == 0) offer(lpcp_pkg::OP_LINE, any_coord(2), any_coord(2),
                                            any_coord(2), any_coord(2), -1);
        wait_drained();
    endtask

    initial begin
        stim_row_t table_rows[$];
        errors         = 0;
        sent           = 0;
        cycles         = 0;
        poly_n         = 0;
        hit_n          = 0;
        hold_off_req   = 1'b0;
        send_idle_pct  = 32;
        recv_stall_pct = 70;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= lpcp_pkg::OP_CLEAR;
        s_tdata  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        table_rows = '{
            // query before any line answers zero
            '{lpcp_pkg::OP_QUERY,   20'sd5,       20'sd5,       20'sd0, 20'sd0, 0},
            // line over an empty polygon leaves nothing
            '{lpcp_pkg::OP_LINE,   -20'sd5,       20'sd1,       20'sd9, 20'sd1, -1},
            '{lpcp_pkg::OP_QUERY,   20'sd100,     20'sd100,     20'sd0, 20'sd0, 0},
            '{lpcp_pkg::OP_APPEND,  20'sd0,       20'sd0,       20'sd0, 20'sd0, -1},
            '{lpcp_pkg::OP_APPEND,  20'sd10,      20'sd0,       20'sd0, 20'sd0, -1},
            '{lpcp_pkg::OP_APPEND,  20'sd0,       20'sd10,      20'sd0, 20'sd0, -1},
            '{lpcp_pkg::OP_LINE,   -20'sd5,       20'sd5,       20'sd20, 20'sd5, -1},
            '{lpcp_pkg::OP_QUERY,  -20'sd100,     20'sd0,       20'sd0, 20'sd0, 0},
            '{lpcp_pkg::OP_QUERY,   20'sd1,       20'sd5,       20'sd0, 20'sd0, -1},
            '{lpcp_pkg::OP_QUERY,   20'sd6,       20'sd5,       20'sd0, 20'sd0, -1},
            // line along an edge, and a degenerate line of one point
            '{lpcp_pkg::OP_LINE,    20'sd0,       20'sd0,       20'sd5, 20'sd0, -1},
            '{lpcp_pkg::OP_QUERY,   20'sd11,      20'sd0,       20'sd0, 20'sd0, -1},
            '{lpcp_pkg::OP_LINE,    20'sd3,       20'sd3,       20'sd3, 20'sd3, -1},
            '{lpcp_pkg::OP_QUERY,   20'sd11,      20'sd11,      20'sd0, 20'sd0, 0},
            // clear keeps the crossings until the next line
            '{lpcp_pkg::OP_LINE,    20'sd2,      -20'sd5,       20'sd2, 20'sd20, -1},
            '{lpcp_pkg::OP_CLEAR,   20'sd0,       20'sd0,       20'sd0, 20'sd0, -1},
            '{lpcp_pkg::OP_QUERY,   20'sd2,       20'sd9,       20'sd0, 20'sd0, -1},
            // extreme coordinates
            '{lpcp_pkg::OP_APPEND, -20'sd524288, -20'sd524288,  20'sd0, 20'sd0, -1},
            '{lpcp_pkg::OP_APPEND,  20'sd524287, -20'sd524288,  20'sd0, 20'sd0, -1},
            '{lpcp_pkg::OP_APPEND,  20'sd524287,  20'sd524287,  20'sd0, 20'sd0, -1},
            '{lpcp_pkg::OP_APPEND, -20'sd524288,  20'sd524287,  20'sd0, 20'sd0, -1},
            '{lpcp_pkg::OP_LINE,   -20'sd524288,  20'sd524287,  20'sd524287, -20'sd524288, -1},
            '{lpcp_pkg::OP_QUERY,   20'sd524287,  20'sd524287,  20'sd0, 20'sd0, -1},
            '{lpcp_pkg::OP_QUERY,   20'sd0,       20'sd0,       20'sd0, 20'sd0, -1},
            // one-vertex polygon has a zero-length edge
            '{lpcp_pkg::OP_CLEAR,   20'sd0,       20'sd0,       20'sd0, 20'sd0, -1}
        };
        foreach (table_rows[i])
            offer(table_rows[i].op, table_rows[i].px, table_rows[i].py,
                  table_rows[i].qx, table_rows[i].qy, table_rows[i].typed);
        offer(lpcp_pkg::OP_APPEND, 20'sd7, 20'sd7, 20'sd0, 20'sd0, -1);
        offer(lpcp_pkg::OP_LINE, 20'sd0, 20'sd0, 20'sd9, 20'sd9, -1);
        offer(lpcp_pkg::OP_QUERY, 20'sd9, 20'sd9, 20'sd0, 20'sd0, 0);
        wait_drained();

        // receiver holds off while queries keep coming
        hold_off_req = 1'b1;
        for (int i = 0; i < 6; i++)
            offer(lpcp_pkg::OP_QUERY, any_coord(1), any_coord(1), 20'sd0, 20'sd0, -1);
        wait_drained();

        while (sent < ITEM_GOAL) begin
            if (sent > ITEM_GOAL / 3 && send_idle_pct == 32) begin
                send_idle_pct  = 70;
                recv_stall_pct = 32;
            end else if (sent > 2 * ITEM_GOAL / 3 && send_idle_pct == 70) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            polygon_round();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && parity_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            if (parity_due.size() != 0)
                $error("parity: %0d results never arrived", parity_due.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
